/* hw/rtl/shacal_pkg.sv */
// Shared types, constants and the round function for the SHACAL-2 encryptor.
`default_nettype none

package shacal_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 8;
  localparam int KEY_DEPTH   = 64;
  localparam int KEY_IDX_W   = $clog2(KEY_DEPTH);
  localparam int ROUNDS_DEF  = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [WORD_W-1:0]                word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ENCRYPT = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [KEY_IDX_W-1:0] key_index;
    word_t                key_word;
    words_t               block;
  } cmd_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // One SHA-256 compression round; word 0 is A, word 7 is H.
  function automatic words_t sha_round(input words_t w, input word_t rk);
    word_t  s1;
    word_t  ch;
    word_t  t1;
    word_t  s0;
    word_t  mj;
    word_t  t2;
    words_t r;
    s1 = rotr(w[4], 6) ^ rotr(w[4], 11) ^ rotr(w[4], 25);
    ch = (w[4] & w[5]) ^ (~w[4] & w[6]);
    t1 = w[7] + s1 + ch + rk;
    s0 = rotr(w[0], 2) ^ rotr(w[0], 13) ^ rotr(w[0], 22);
    mj = (w[0] & w[1]) ^ (w[0] & w[2]) ^ (w[1] & w[2]);
    t2 = s0 + mj;
    r[7] = w[6];
    r[6] = w[5];
    r[5] = w[4];
    r[4] = w[3] + t1;
    r[3] = w[2];
    r[2] = w[1];
    r[1] = w[0];
    r[0] = t1 + t2;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/shacal_front.sv */
// Front end: accepts input transactions, classifies them and queues them.
`default_nettype none

module shacal_front
  import shacal_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 op,
  input  wire logic [KEY_IDX_W-1:0] key_index,
  input  wire word_t                key_word,
  input  wire words_t               block,
  output logic                      cmd_valid,
  output cmd_t                      cmd,
  input  wire logic                 cmd_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             in_cmd;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    in_cmd.kind      = op ? CMD_ENCRYPT : CMD_LOAD;
    in_cmd.key_index = key_index;
    in_cmd.key_word  = key_word;
    in_cmd.block     = block;
  end

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/shacal_core.sv */
// Back end: round word store, iterative SHA-256 round engine and result register.
`default_nettype none

module shacal_core
  import shacal_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  output words_t    out_words,
  input  wire logic out_pop
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t               state_r;
  logic [KEY_IDX_W-1:0] cnt_r;
  words_t               ww_r;
  word_t                rk_r;
  logic                 out_valid_r;
  words_t               out_words_r;
  word_t                key_mem_r [KEY_DEPTH];

  logic                 take;
  logic                 last;
  logic                 advance;
  logic [KEY_IDX_W-1:0] rd_addr;
  words_t               round_w;

  assign take    = (state_r == ST_IDLE) && cmd_valid;
  assign last    = (cnt_r == KEY_IDX_W'(ROUNDS - 1));
  // the final round waits until the result register is free
  assign advance = (state_r == ST_RUN) && !(last && out_valid_r && !out_pop);
  assign rd_addr = take ? '0 : cnt_r + KEY_IDX_W'(1);
  assign round_w = sha_round(ww_r, rk_r);

  assign cmd_pop   = take;
  assign out_valid = out_valid_r;
  assign out_words = out_words_r;

  // Round word prefetch: rk_r holds the word for the round in cnt_r.
  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_LOAD) begin
      key_mem_r[cmd.key_index] <= cmd.key_word;
    end
    if (take || advance) begin
      rk_r <= key_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ww_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (take && cmd.kind == CMD_ENCRYPT) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
            ww_r    <= cmd.block;
          end
        end
        ST_RUN: begin
          if (advance) begin
            ww_r  <= round_w;
            cnt_r <= cnt_r + KEY_IDX_W'(1);
            if (last) begin
              state_r     <= ST_IDLE;
              out_valid_r <= 1'b1;
              out_words_r <= round_w;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/shacal2_block_encrypt.sv */
// Top level of the SHACAL-2 block encryptor.
//
// Input queue: a transaction is taken when in_push is high and in_full low.
// in_op = 0 loads in_key_word as round word in_key_index; in_op = 1 encrypts
// the eight block words. All ROUNDS round words must be loaded first.
// Result queue: while out_empty is low the ciphertext is on out_cipher_word_*;
// it is taken when out_pop is high. Loads give no result.
// Transactions pass a two-entry command queue, then execute in order.
// A block waits in the queue until the round engine is idle; it is then
// dequeued and round word 0 is prefetched, and the engine runs ROUNDS
// SHA-256 rounds, one per cycle while its final round is not stalled.
// Blocks are encrypted one at a time by the single round engine; a load
// is taken by the idle engine and starts no rounds.
// Stall: a pending result holds; the next block runs up to its final round
// and waits there, while the queue keeps taking transactions until full.
// Reset (synchronous, active low) empties both queues and clears the state;
// round words are undefined until loaded.
`default_nettype none

module shacal2_block_encrypt
  import shacal_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_op,
  input  wire logic [KEY_IDX_W-1:0] in_key_index,
  input  wire word_t                in_key_word,
  input  wire word_t                in_block_word_0,
  input  wire word_t                in_block_word_1,
  input  wire word_t                in_block_word_2,
  input  wire word_t                in_block_word_3,
  input  wire word_t                in_block_word_4,
  input  wire word_t                in_block_word_5,
  input  wire word_t                in_block_word_6,
  input  wire word_t                in_block_word_7,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output word_t                     out_cipher_word_0,
  output word_t                     out_cipher_word_1,
  output word_t                     out_cipher_word_2,
  output word_t                     out_cipher_word_3,
  output word_t                     out_cipher_word_4,
  output word_t                     out_cipher_word_5,
  output word_t                     out_cipher_word_6,
  output word_t                     out_cipher_word_7
);

  words_t block;
  words_t cipher;
  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_pop;
  logic   out_valid;

  assign block[0] = in_block_word_0;
  assign block[1] = in_block_word_1;
  assign block[2] = in_block_word_2;
  assign block[3] = in_block_word_3;
  assign block[4] = in_block_word_4;
  assign block[5] = in_block_word_5;
  assign block[6] = in_block_word_6;
  assign block[7] = in_block_word_7;

  shacal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .op        (in_op),
    .key_index (in_key_index),
    .key_word  (in_key_word),
    .block     (block),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  shacal_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_words (cipher),
    .out_pop   (out_pop)
  );

  assign out_empty         = !out_valid;
  assign out_cipher_word_0 = cipher[0];
  assign out_cipher_word_1 = cipher[1];
  assign out_cipher_word_2 = cipher[2];
  assign out_cipher_word_3 = cipher[3];
  assign out_cipher_word_4 = cipher[4];
  assign out_cipher_word_5 = cipher[5];
  assign out_cipher_word_6 = cipher[6];
  assign out_cipher_word_7 = cipher[7];

endmodule

`default_nettype wire

/* hw/rtl/shacal_checker.sv */
// Port-level checks for the SHACAL-2 encryptor, bound to the top level.
`default_nettype none

module shacal_checker
  import shacal_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_full,
  input wire logic  out_empty,
  input wire logic  out_pop,
  input wire word_t out_cipher_word_0,
  input wire word_t out_cipher_word_7
);

  // a waiting result stays until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result withdrawn before pop");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_cipher_word_0) && $stable(out_cipher_word_7))
    else $error("stalled result changed");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  a_reset_queue_free: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("input queue full after reset");

endmodule

bind shacal2_block_encrypt shacal_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_cipher_word_0 (out_cipher_word_0),
  .out_cipher_word_7 (out_cipher_word_7)
);

`default_nettype wire
